/* rtl/sfk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfk_pkg
// Types and constants for the skeletal forward kinematics block.
// ----------------------------------------------------------------------------
package sfk_pkg;

    localparam logic [1:0] FLAG_POP  = 2'b01;
    localparam logic [1:0] FLAG_PUSH = 2'b10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_LROT,
        ST_LRND,
        ST_PROT,
        ST_PRND,
        ST_TRN,
        ST_TRND,
        ST_WR,
        ST_OUT
    } state_t;

    typedef logic signed [15:0] rot_t;
    typedef logic signed [31:0] trn_t;

    function automatic rot_t sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) begin
            return 16'sh7fff;
        end
        if (v < -48'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic trn_t sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

/* rtl/skeletal_forward_kinematics.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skeletal_forward_kinematics
// Per-bone absolute 3x4 transform from offset, quaternion and a parent stack.
// One shared 32x16 multiplier; each product term is registered before it is
// added, and bones with no parent skip the parent multiply states.
// One bone at a time: s_ready stays low from the input transfer until the
// third row transfer, so output stalls hold off the next bone.
// Reset: synchronous active low; stack size to one (the none entry is written by the next root), bone 0.
// ----------------------------------------------------------------------------
module skeletal_forward_kinematics #(
    parameter int MAX_BONES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_first_bone,
    input  logic [1:0]  s_stack_flags,
    input  logic signed [31:0] s_offset_x,
    input  logic signed [31:0] s_offset_y,
    input  logic signed [31:0] s_offset_z,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic signed [31:0] s_root_pos_x,
    input  logic signed [31:0] s_root_pos_y,
    input  logic signed [31:0] s_root_pos_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_bone_number,
    output logic [1:0]  m_row_number,
    output logic signed [15:0] m_rot_col0,
    output logic signed [15:0] m_rot_col1,
    output logic signed [15:0] m_rot_col2,
    output logic signed [31:0] m_translation,
    output logic        m_last_row
);
    import sfk_pkg::*;

    localparam int BW  = $clog2(MAX_BONES);
    localparam int SW  = $clog2(MAX_BONES + 1);
    localparam int PW  = BW + 1;
    localparam int RAW = $clog2(MAX_BONES * 9);
    localparam int TAW = $clog2(MAX_BONES * 3);

    state_t state_reg, state_next;

    logic [6:0]    bone_count_reg;
    logic [SW-1:0] stack_size_reg;
    logic [BW-1:0] cur_reg;
    logic [PW-1:0] parent_stack [MAX_BONES];
    logic [PW-1:0] stack_top_reg;
    rot_t          rot_mem [MAX_BONES*9];
    trn_t          trn_mem [MAX_BONES*3];

    logic [BW-1:0] idx_reg;
    logic [PW-1:0] parent_reg;
    logic          has_par_reg;
    logic signed [15:0] q_reg [4];
    trn_t          lt_reg [3];
    rot_t          lr_reg [9];
    rot_t          pr_reg [9];
    trn_t          pt_reg [3];
    rot_t          rot_reg [9];
    trn_t          tr_reg [3];
    logic [3:0]    k_reg;
    logic [1:0]    j_reg;
    logic signed [63:0] acc_reg;
    logic signed [47:0] prod_reg;
    logic          pv_reg;
    logic [1:0]    row_reg;

    // Shared multiplier operands
    logic signed [31:0] ma;
    logic signed [15:0] mb;
    logic               mneg;
    logic signed [63:0] mfix;
    logic               mlast;

    // local rotation term table: {k, j} index over 0..17 for (elem, term)
    logic [3:0] li;
    logic [3:0] prow;
    logic [1:0] pcol;
    always_comb begin
        ma = '0;
        mb = '0;
        mneg = 1'b0;
        mfix = '0;
        mlast = 1'b0;
        unique case (state_reg)
            ST_LROT: begin
                // elem k_reg, two terms j; Q4.28 terms doubled via shift on add
                mlast = (j_reg == 2'd1);
                unique case ({k_reg, j_reg[0]})
                    5'd0:  begin ma = 32'(q_reg[2]); mb = q_reg[2]; mneg = 1'b1; end
                    5'd1:  begin ma = 32'(q_reg[3]); mb = q_reg[3]; mneg = 1'b1; end
                    5'd2:  begin ma = 32'(q_reg[1]); mb = q_reg[2]; end
                    5'd3:  begin ma = 32'(q_reg[0]); mb = q_reg[3]; mneg = 1'b1; end
                    5'd4:  begin ma = 32'(q_reg[1]); mb = q_reg[3]; end
                    5'd5:  begin ma = 32'(q_reg[0]); mb = q_reg[2]; end
                    5'd6:  begin ma = 32'(q_reg[1]); mb = q_reg[2]; end
                    5'd7:  begin ma = 32'(q_reg[0]); mb = q_reg[3]; end
                    5'd8:  begin ma = 32'(q_reg[1]); mb = q_reg[1]; mneg = 1'b1; end
                    5'd9:  begin ma = 32'(q_reg[3]); mb = q_reg[3]; mneg = 1'b1; end
                    5'd10: begin ma = 32'(q_reg[2]); mb = q_reg[3]; end
                    5'd11: begin ma = 32'(q_reg[0]); mb = q_reg[1]; mneg = 1'b1; end
                    5'd12: begin ma = 32'(q_reg[1]); mb = q_reg[3]; end
                    5'd13: begin ma = 32'(q_reg[0]); mb = q_reg[2]; mneg = 1'b1; end
                    5'd14: begin ma = 32'(q_reg[2]); mb = q_reg[3]; end
                    5'd15: begin ma = 32'(q_reg[0]); mb = q_reg[1]; end
                    5'd16: begin ma = 32'(q_reg[1]); mb = q_reg[1]; mneg = 1'b1; end
                    5'd17: begin ma = 32'(q_reg[2]); mb = q_reg[2]; mneg = 1'b1; end
                    default: ;
                endcase
                if (k_reg == 4'd0 || k_reg == 4'd4 || k_reg == 4'd8) begin
                    mfix = 64'sd1 <<< 28;
                end
            end
            ST_PROT: begin
                // rot[k] = sum_i pr[r*3+i]*lr[i*3+c]
                mlast = (j_reg == 2'd2);
                ma = 32'(pr_reg[li]);
                mb = lr_reg[4'(j_reg) * 4'd3 + 4'(pcol)];
            end
            ST_TRN: begin
                mlast = (j_reg == 2'd2);
                ma = lt_reg[j_reg];
                mb = pr_reg[li];
            end
            default: ;
        endcase
    end

    // row base and column of element k
    always_comb begin
        priority if (k_reg < 4'd3) begin
            prow = 4'd0;
            pcol = k_reg[1:0];
        end else if (k_reg < 4'd6) begin
            prow = 4'd3;
            pcol = 2'(k_reg - 4'd3);
        end else begin
            prow = 4'd6;
            pcol = 2'(k_reg - 4'd6);
        end
        li = prow + 4'(j_reg);
        if (state_reg == ST_TRN) begin
            li = 4'(k_reg) * 4'd3 + 4'(j_reg);
        end
    end

    logic signed [63:0] term;
    logic signed [63:0] acc_sum;
    always_comb begin
        term = 64'(prod_reg);
        if (state_reg == ST_LROT) begin
            term = term <<< 1;
        end
        if (pv_reg && mneg) begin
            term = -term;
        end
        acc_sum = acc_reg + term;
    end

    logic signed [63:0] rnd14;
    assign rnd14 = (acc_reg + 64'sd8192) >>> 14;

    logic [PW-1:0] pop_par;
    logic [SW-1:0] sz_pop;
    logic          do_pop, do_push, is_root;
    always_comb begin
        is_root = s_first_bone || (cur_reg == '0);
        do_pop  = !is_root && ((s_stack_flags & FLAG_POP) != '0) && (stack_size_reg != '0);
        sz_pop  = do_pop ? stack_size_reg - SW'(1) : stack_size_reg;
        pop_par = stack_top_reg;
        do_push = !is_root && ((s_stack_flags & FLAG_PUSH) != '0)
                  && (32'(sz_pop) + 32'd1 < 32'(bone_count_reg))
                  && (32'(sz_pop) < MAX_BONES);
    end

    logic [PW-1:0] par_w;
    assign par_w = is_root ? PW'(MAX_BONES)
                 : (do_pop ? pop_par : PW'(cur_reg) - PW'(1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_RD;
            ST_RD:   if (k_reg == 4'd11) state_next = ST_LROT;
            ST_LROT: if (mlast && pv_reg && k_reg == 4'd8) state_next = ST_LRND;
            ST_LRND: state_next = has_par_reg ? ST_PROT : ST_WR;
            ST_PROT: if (mlast && pv_reg) state_next = ST_PRND;
            ST_PRND: state_next = (k_reg == 4'd8) ? ST_TRN : ST_PROT;
            ST_TRN:  if (mlast && pv_reg) state_next = ST_TRND;
            ST_TRND: state_next = (k_reg == 4'd2) ? ST_WR : ST_TRN;
            ST_WR:   if (k_reg == 4'd11) state_next = ST_OUT;
            ST_OUT:  if (m_ready && row_reg == 2'd2) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = (state_reg == ST_OUT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            bone_count_reg <= 7'd1;
            stack_size_reg <= SW'(1);
            cur_reg        <= '0;
            pv_reg         <= 1'b0;
            k_reg          <= '0;
            j_reg          <= '0;
            row_reg        <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                bone_count_reg <= cfg_wdata;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    k_reg <= '0;
                    if (s_valid) begin
                        if (is_root) begin
                            stack_size_reg <= SW'(1);
                        end else if (do_push) begin
                            stack_size_reg <= sz_pop + SW'(1);
                        end else begin
                            stack_size_reg <= sz_pop;
                        end
                    end
                end
                ST_RD: begin
                    k_reg <= (k_reg == 4'd11) ? 4'd0 : k_reg + 4'd1;
                    j_reg <= '0;
                    pv_reg <= 1'b0;
                end
                ST_LROT, ST_PROT, ST_TRN: begin
                    if (!pv_reg) begin
                        pv_reg <= 1'b1;
                    end else if (mlast) begin
                        pv_reg <= 1'b0;
                        j_reg  <= '0;
                        if (state_reg == ST_LROT && k_reg != 4'd8) begin
                            k_reg <= k_reg + 4'd1;
                        end
                    end else begin
                        pv_reg <= 1'b0;
                        j_reg  <= j_reg + 2'd1;
                    end
                end
                ST_LRND: k_reg <= '0;
                ST_PRND: k_reg <= (k_reg == 4'd8) ? 4'd0 : k_reg + 4'd1;
                ST_TRND: k_reg <= (k_reg == 4'd2) ? 4'd0 : k_reg + 4'd1;
                ST_WR: begin
                    k_reg <= (k_reg == 4'd11) ? 4'd0 : k_reg + 4'd1;
                    row_reg <= '0;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        row_reg <= row_reg + 2'd1;
                        if (row_reg == 2'd2) begin
                            cur_reg <= (32'(idx_reg) == MAX_BONES - 1) ? '0
                                     : idx_reg + BW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        prod_reg <= 48'(ma) * 48'(mb);
        stack_top_reg <= parent_stack[BW'(stack_size_reg - SW'(1))];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    idx_reg     <= is_root ? '0 : cur_reg;
                    parent_reg  <= par_w;
                    has_par_reg <= (32'(par_w) < MAX_BONES);
                    q_reg[0] <= s_quat_w;
                    q_reg[1] <= s_quat_x;
                    q_reg[2] <= s_quat_y;
                    q_reg[3] <= s_quat_z;
                    lt_reg[0] <= is_root ? sat32(64'(s_offset_x) + 64'(s_root_pos_x)) : s_offset_x;
                    lt_reg[1] <= is_root ? sat32(64'(s_offset_y) + 64'(s_root_pos_y)) : s_offset_y;
                    lt_reg[2] <= is_root ? sat32(64'(s_offset_z) + 64'(s_root_pos_z)) : s_offset_z;
                    if (is_root) begin
                        parent_stack[0] <= PW'(MAX_BONES);
                    end else if (do_push) begin
                        parent_stack[sz_pop[BW-1:0]] <= par_w;
                    end
                    acc_reg <= '0;
                end
            end
            ST_RD: begin
                if (k_reg < 4'd9) begin
                    pr_reg[k_reg] <= rot_mem[RAW'(parent_reg[BW-1:0]) * RAW'(9)
                                             + RAW'(k_reg)];
                end else begin
                    pt_reg[2'(k_reg - 4'd9)] <= trn_mem[TAW'(parent_reg[BW-1:0]) * TAW'(3)
                                                        + TAW'(k_reg - 4'd9)];
                end
                acc_reg <= '0;
            end
            ST_LROT: begin
                if (pv_reg) begin
                    if (mlast) begin
                        lr_reg[k_reg] <= sat16(48'((acc_sum + mfix + 64'sd8192) >>> 14));
                        acc_reg <= '0;
                    end else begin
                        acc_reg <= acc_sum;
                    end
                end
            end
            ST_PROT, ST_TRN: begin
                if (pv_reg) begin
                    acc_reg <= acc_sum;
                end
            end
            ST_LRND: begin
                rot_reg <= lr_reg;
                tr_reg  <= lt_reg;
                acc_reg <= '0;
            end
            ST_PRND: begin
                rot_reg[k_reg] <= sat16(rnd14[47:0]);
                acc_reg <= '0;
            end
            ST_TRND: begin
                tr_reg[k_reg[1:0]] <= sat32(rnd14 + 64'(pt_reg[k_reg[1:0]]));
                acc_reg <= '0;
            end
            ST_WR: begin
                if (k_reg < 4'd9) begin
                    rot_mem[RAW'(idx_reg) * RAW'(9) + RAW'(k_reg)] <= rot_reg[k_reg];
                end else begin
                    trn_mem[TAW'(idx_reg) * TAW'(3) + TAW'(k_reg - 4'd9)]
                        <= tr_reg[2'(k_reg - 4'd9)];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        m_bone_number = 6'(idx_reg);
        m_row_number  = row_reg;
        m_rot_col0    = rot_reg[4'(row_reg) * 4'd3];
        m_rot_col1    = rot_reg[4'(row_reg) * 4'd3 + 4'd1];
        m_rot_col2    = rot_reg[4'(row_reg) * 4'd3 + 4'd2];
        m_translation = tr_reg[row_reg];
        m_last_row    = (row_reg == 2'd2);
    end

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready during output");
    a_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> row_reg != 2'd3) else $error("bad row");
    a_stack: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(stack_size_reg) <= MAX_BONES) else $error("stack overflow");

endmodule

/* bench/sfk_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfk_checker
// Watches both channels of the forward kinematics block, works out the three
// absolute transform rows of every accepted bone and compares them in order.
// ----------------------------------------------------------------------------
module sfk_checker
    import sfk_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_first_bone,
    input  logic [1:0]  s_stack_flags,
    input  logic signed [31:0] s_offset_x,
    input  logic signed [31:0] s_offset_y,
    input  logic signed [31:0] s_offset_z,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic signed [31:0] s_root_pos_x,
    input  logic signed [31:0] s_root_pos_y,
    input  logic signed [31:0] s_root_pos_z,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [5:0]  m_bone_number,
    input  logic [1:0]  m_row_number,
    input  logic signed [15:0] m_rot_col0,
    input  logic signed [15:0] m_rot_col1,
    input  logic signed [15:0] m_rot_col2,
    input  logic signed [31:0] m_translation,
    input  logic        m_last_row,
    output int          fails,
    output int          pending
);

    localparam int NBONES = 64;
    localparam int NONE   = NBONES;

    typedef struct {
        logic [5:0]  bone;
        logic [1:0]  row;
        rot_t        c0;
        rot_t        c1;
        rot_t        c2;
        trn_t        trn;
        logic        last;
    } xform_row_t;

    xform_row_t rows_due[$];

    rot_t   abs_rot[NBONES*9];
    trn_t   abs_trn[NBONES*3];
    int     parent_stk[NBONES];
    int     stk_n;
    int     next_bone;
    int     bone_cnt;

    function automatic rot_t clip16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic trn_t clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // round half up then arithmetic shift: floor((v + 2^(s-1)) / 2^s)
    function automatic longint rnd(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    task automatic forward_bone();
        int idx, par, r, c, i;
        longint w, x, y, z, acc, sum;
        longint lr[9];
        longint lt[3];
        longint ofs[3];
        longint rp[3];
        rot_t rot[9];
        trn_t tr[3];
        xform_row_t e;
        idx = next_bone % NBONES;
        w = s_quat_w; x = s_quat_x; y = s_quat_y; z = s_quat_z;
        ofs[0] = s_offset_x; ofs[1] = s_offset_y; ofs[2] = s_offset_z;
        rp[0] = s_root_pos_x; rp[1] = s_root_pos_y; rp[2] = s_root_pos_z;
        if (s_first_bone || idx == 0) begin
            idx = 0;
            par = NONE;
            stk_n = 1;
            parent_stk[0] = NONE;
        end else begin
            par = idx - 1;
            if ((s_stack_flags & FLAG_POP) != 0 && stk_n > 0) begin
                stk_n--;
                par = parent_stk[stk_n];
            end
            if ((s_stack_flags & FLAG_PUSH) != 0 && stk_n + 1 < bone_cnt && stk_n < NBONES) begin
                parent_stk[stk_n] = par;
                stk_n++;
            end
        end
        lr[0] = (64'sd1 <<< 28) - 2 * (y * y + z * z);
        lr[1] = 2 * (x * y - w * z);
        lr[2] = 2 * (x * z + w * y);
        lr[3] = 2 * (x * y + w * z);
        lr[4] = (64'sd1 <<< 28) - 2 * (x * x + z * z);
        lr[5] = 2 * (y * z - w * x);
        lr[6] = 2 * (x * z - w * y);
        lr[7] = 2 * (y * z + w * x);
        lr[8] = (64'sd1 <<< 28) - 2 * (x * x + y * y);
        for (i = 0; i < 9; i++) lr[i] = clip16(rnd(lr[i], 14));
        for (i = 0; i < 3; i++) lt[i] = clip32(idx == 0 ? ofs[i] + rp[i] : ofs[i]);
        if (par >= NBONES) begin
            for (i = 0; i < 9; i++) rot[i] = lr[i][15:0];
            for (i = 0; i < 3; i++) tr[i] = lt[i][31:0];
        end else begin
            for (r = 0; r < 3; r++) begin
                for (c = 0; c < 3; c++) begin
                    sum = 0;
                    for (i = 0; i < 3; i++) sum += longint'(abs_rot[par*9 + r*3 + i]) * lr[i*3 + c];
                    rot[r*3 + c] = clip16(rnd(sum, 14));
                end
                acc = 0;
                for (i = 0; i < 3; i++) acc += longint'(abs_rot[par*9 + r*3 + i]) * lt[i];
                tr[r] = clip32(rnd(acc, 14) + longint'(abs_trn[par*3 + r]));
            end
        end
        for (i = 0; i < 9; i++) abs_rot[idx*9 + i] = rot[i];
        for (i = 0; i < 3; i++) abs_trn[idx*3 + i] = tr[i];
        for (r = 0; r < 3; r++) begin
            e.bone = idx[5:0];
            e.row  = r[1:0];
            e.c0   = rot[r*3];
            e.c1   = rot[r*3 + 1];
            e.c2   = rot[r*3 + 2];
            e.trn  = tr[r];
            e.last = (r == 2);
            rows_due.push_back(e);
        end
        next_bone = (idx + 1) % NBONES;
    endtask

    task automatic check_row();
        xform_row_t e;
        if (rows_due.size() == 0) begin
            $error("row transfer with nothing expected: bone %0d row %0d",
                m_bone_number, m_row_number);
            fails++;
        end else begin
            e = rows_due.pop_front();
            if (m_bone_number !== e.bone) begin
                $error("bone_number expected %0d got %0d", e.bone, m_bone_number); fails++;
            end
            if (m_row_number !== e.row) begin
                $error("row_number expected %0d got %0d", e.row, m_row_number); fails++;
            end
            if (m_rot_col0 !== e.c0) begin
                $error("rot_col0 expected %0d got %0d", e.c0, m_rot_col0); fails++;
            end
            if (m_rot_col1 !== e.c1) begin
                $error("rot_col1 expected %0d got %0d", e.c1, m_rot_col1); fails++;
            end
            if (m_rot_col2 !== e.c2) begin
                $error("rot_col2 expected %0d got %0d", e.c2, m_rot_col2); fails++;
            end
            if (m_translation !== e.trn) begin
                $error("translation expected %0d got %0d", e.trn, m_translation); fails++;
            end
            if (m_last_row !== e.last) begin
                $error("last_row expected %0d got %0d", e.last, m_last_row); fails++;
            end
        end
    endtask

    initial begin
        fails = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            bone_cnt = 1;
            stk_n = 1;
            parent_stk[0] = NONE;
            next_bone = 0;
            rows_due.delete();
        end else begin
            if (cfg_we) bone_cnt = cfg_wdata;
            if (m_valid && m_ready) check_row();
            if (s_valid && s_ready) forward_bone();
        end
        pending = rows_due.size();
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives skeletons of bones through the forward kinematics block under
// several bone counts, with random stalls on both sides and one long output
// hold-off; the checker beside the block compares every transform row.
// ----------------------------------------------------------------------------
module testbench;
    import sfk_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_first_bone = 1'b0;
    logic [1:0]  s_stack_flags = '0;
    logic signed [31:0] s_offset_x = '0, s_offset_y = '0, s_offset_z = '0;
    logic signed [15:0] s_quat_w = '0, s_quat_x = '0, s_quat_y = '0, s_quat_z = '0;
    logic signed [31:0] s_root_pos_x = '0, s_root_pos_y = '0, s_root_pos_z = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [5:0]  m_bone_number;
    logic [1:0]  m_row_number;
    logic signed [15:0] m_rot_col0, m_rot_col1, m_rot_col2;
    logic signed [31:0] m_translation;
    logic        m_last_row;
    int          fails;
    int          pending;

    logic        quiet = 1'b0;
    logic        press_req = 1'b0;
    logic        press_done = 1'b0;
    int          hold_cnt = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    skeletal_forward_kinematics i_dut (.*);

    sfk_checker i_chk (.*);

    // output side: random stall bursts plus one long hold-off
    always @(posedge aclk) begin
        if (press_req && !press_done) begin
            press_done <= 1'b1;
            hold_cnt <= 400;
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
            hold_cnt <= $urandom_range(0, 13);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic set_bone_count(input logic [6:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_bone(input logic first, input logic [1:0] flags,
                             input logic [31:0] ox, oy, oz,
                             input logic [15:0] qw, qx, qy, qz,
                             input logic [31:0] rx, ry, rz);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_first_bone <= first;
        s_stack_flags <= flags;
        s_offset_x <= ox; s_offset_y <= oy; s_offset_z <= oz;
        s_quat_w <= qw; s_quat_x <= qx; s_quat_y <= qy; s_quat_z <= qz;
        s_root_pos_x <= rx; s_root_pos_y <= ry; s_root_pos_z <= rz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_offset();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    endfunction

    function automatic logic [15:0] rand_quat_part();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 16384)) - 8192);
    endfunction

    task automatic send_random_bone(input logic first);
        send_bone(first, 2'($urandom_range(0, 3)), rand_offset(), rand_offset(), rand_offset(),
            rand_quat_part(), rand_quat_part(), rand_quat_part(), rand_quat_part(),
            rand_offset(), rand_offset(), rand_offset());
    endtask

    task automatic send_skeletons(input int total);
        int sent, len, k;
        sent = 0;
        while (sent < total) begin
            len = $urandom_range(1, 20);
            for (k = 0; k < len && sent < total; k++) begin
                // a stray root now and then breaks a sequence
                send_random_bone(k == 0 || $urandom_range(0, 40) == 0);
                sent++;
            end
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    initial begin
        int k;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_bone_count(7'd64);
        send_bone(1'b1, FLAG_PUSH, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            16'h4000, 16'h0000, 16'h0000, 16'h0000, 32'h7fffffff, 32'h00000001, 32'h80000000);
        send_bone(1'b0, FLAG_POP, 32'h00000100, 32'h0, 32'h0,
            16'h0000, 16'h4000, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
        send_bone(1'b0, FLAG_POP, 32'h0, 32'h00000200, 32'h0,
            16'h2d41, 16'h0000, 16'h2d41, 16'h0000, 32'h0, 32'h0, 32'h0);
        send_bone(1'b0, FLAG_PUSH, 32'h80000000, 32'h80000000, 32'h80000000,
            16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h0, 32'h0, 32'h0);
        send_bone(1'b0, FLAG_PUSH, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
            16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 32'h0, 32'h0, 32'h0);
        send_bone(1'b0, FLAG_PUSH | FLAG_POP, 32'h00001000, 32'hfffff000, 32'h0,
            16'h0000, 16'h0000, 16'h0000, 16'h4000, 32'h0, 32'h0, 32'h0);
        send_bone(1'b0, FLAG_POP, 32'h0, 32'h0, 32'h00000080,
            16'h4000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
        send_bone(1'b0, FLAG_POP, 32'h0, 32'h0, 32'h0,
            16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
        send_bone(1'b0, FLAG_POP, 32'h0, 32'h0, 32'h0,
            16'hc000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
        send_bone(1'b1, 2'b11, 32'h80000000, 32'h80000000, 32'h0,
            16'h4000, 16'h0000, 16'h0000, 16'h0000, 32'h80000000, 32'hffffffff, 32'h0);
        drain();

        // push limit at its tightest, and a long skeleton that wraps the index
        set_bone_count(7'd1);
        for (k = 0; k < 70; k++) send_random_bone(k == 0);
        drain();

        set_bone_count(7'd2);
        press_req <= 1'b1;
        send_skeletons(80);
        drain();

        set_bone_count(7'd63);
        send_skeletons(100);
        drain();

        set_bone_count(7'($urandom_range(3, 62)));
        send_skeletons(80);
        drain();

        set_bone_count(7'd64);
        send_skeletons(40);
        quiet <= 1'b1;
        send_skeletons(40);
        drain();

        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
